FILE: rtl/adam_pkg.sv
// Shared constants, types and step functions for the Adam update core.
package adam_pkg;

    localparam int MEM_DEPTH = 4096;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam int IDX_W  = 12;
    localparam int VAL_W  = 32;
    localparam int LR_W   = 24;
    localparam int BETA_W = 16;
    localparam int PW_W   = 32;
    localparam int V_W    = 48;
    localparam int C_W    = PW_W + 1;
    localparam int MEM_W  = VAL_W + V_W;

    localparam int SQ_IN_W   = 64;
    localparam int SQ_ROOT_W = 32;
    localparam int SQ_REM_W  = SQ_ROOT_W + 4;
    localparam int SQ_STEPS  = 4;
    localparam int SQ_STAGES = SQ_ROOT_W / SQ_STEPS;

    localparam int N_W        = 61;
    localparam int D_W        = 49;
    localparam int NUM_SPLIT  = 24;
    localparam int FRAC_EXT   = 10;
    localparam int Q_W        = NUM_SPLIT + FRAC_EXT;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = Q_W / DIV_STEPS;

    localparam logic [LR_W-1:0]   LR_RESET = 24'd16777;
    localparam logic [BETA_W-1:0] B1_RESET = 16'd58982;
    localparam logic [BETA_W-1:0] B2_RESET = 16'd65470;
    localparam logic [20:0]       EPS_Q40  = 21'd1099512;
    localparam logic [Q_W-1:0]    U_CAP    = 34'h2_0000_0000;

    typedef enum logic [1:0] {
        REG_LR = 2'd0,
        REG_B1 = 2'd1,
        REG_B2 = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [SQ_IN_W-1:0]   x;
        logic [SQ_ROOT_W-1:0] root;
        logic [SQ_REM_W-1:0]  rem;
    } t_sq_state;

    typedef struct packed {
        logic [D_W-1:0] rem;
        logic [Q_W-1:0] lo;
        logic [Q_W-1:0] q;
        logic [D_W-1:0] den;
        logic           sat;
    } t_div_state;

    // Restoring square root, two radicand bits per step.
    function automatic t_sq_state sq_steps(t_sq_state s);
        t_sq_state             r;
        logic [SQ_REM_W-1:0]   sh;
        logic [SQ_REM_W-1:0]   trial;
        r = s;
        for (int k = 0; k < SQ_STEPS; k++) begin
            sh    = {r.rem[SQ_REM_W-3:0], r.x[SQ_IN_W-1 -: 2]};
            trial = SQ_REM_W'({r.root, 2'b01});
            r.x   = {r.x[SQ_IN_W-3:0], 2'b00};
            if (sh >= trial) begin
                r.rem  = sh - trial;
                r.root = {r.root[SQ_ROOT_W-2:0], 1'b1};
            end else begin
                r.rem  = sh;
                r.root = {r.root[SQ_ROOT_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    // Restoring division, one quotient bit per step.
    function automatic t_div_state div_steps(t_div_state s);
        t_div_state   r;
        logic [D_W:0] sh;
        r = s;
        for (int k = 0; k < DIV_STEPS; k++) begin
            sh   = {r.rem, r.lo[Q_W-1]};
            r.lo = {r.lo[Q_W-2:0], 1'b0};
            if (sh >= {1'b0, r.den}) begin
                r.rem = D_W'(sh - {1'b0, r.den});
                r.q   = {r.q[Q_W-2:0], 1'b1};
            end else begin
                r.rem = sh[D_W-1:0];
                r.q   = {r.q[Q_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/adam_sqrt.sv
// Pipelined integer square root, four result bits per stage.
module adam_sqrt import adam_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [SQ_IN_W-1:0]   i_radicand,
    output logic [SQ_ROOT_W-1:0] o_root
);

    t_sq_state r_st [SQ_STAGES];
    t_sq_state n_st [SQ_STAGES];

    always_comb begin
        n_st[0] = sq_steps('{x: i_radicand, root: '0, rem: '0});
        for (int s = 1; s < SQ_STAGES; s++) begin
            n_st[s] = sq_steps(r_st[s-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_root = r_st[SQ_STAGES-1].root;

endmodule

FILE: rtl/adam_div.sv
// Pipelined restoring divider for the scaled step, with overflow flag.
module adam_div import adam_pkg::*; (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic [Q_W-1:0] o_quot,
    output logic           o_sat
);

    t_div_state r_st [DIV_STAGES];
    t_div_state n_st [DIV_STAGES];
    t_div_state init;

    // Quotient of num*2^FRAC_EXT overflows Q_W bits when the high part reaches den.
    always_comb begin
        init.rem = D_W'(i_num[N_W-1:NUM_SPLIT]);
        init.lo  = {i_num[NUM_SPLIT-1:0], FRAC_EXT'(0)};
        init.q   = '0;
        init.den = i_den;
        init.sat = (D_W'(i_num[N_W-1:NUM_SPLIT]) >= i_den);
        n_st[0]  = div_steps(init);
        for (int s = 1; s < DIV_STAGES; s++) begin
            n_st[s] = div_steps(r_st[s-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_quot = r_st[DIV_STAGES-1].q;
    assign o_sat  = r_st[DIV_STAGES-1].sat;

endmodule

FILE: rtl/adam_optimizer_update_core.sv
// Adam optimizer update core: moment stores, bias correction and parameter step.
//
// Throughput: one item per cycle while neither a memory clear nor an output stall holds
// the pipe; the moment read-modify-write closes in a single stage through a one-deep
// forward path, so equal indexes may follow back to back.
// Reset: synchronous, active low; configuration returns to its defaults, the beta
// powers reload, and a clearing pass over all 4096 entries zeroes the moment memory while
// the input side stalls (configuration writes are still taken).
module adam_optimizer_update_core import adam_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [VAL_W-1:0] i_param_value,
    input  logic signed [VAL_W-1:0] i_gradient,
    input  logic [IDX_W-1:0]        i_param_index,
    input  logic                    i_end_of_step,

    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [VAL_W-1:0] o_new_value,
    output logic [IDX_W-1:0]        o_result_index,
    output logic                    o_step_done,

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    typedef struct packed {
        logic [VAL_W-1:0] p;
        logic [VAL_W-1:0] g;
        logic [IDX_W-1:0] idx;
        logic             eos;
        logic [C_W-1:0]   c1;
        logic [C_W-1:0]   c2;
    } t_s0;

    typedef struct packed {
        logic [VAL_W-1:0] p;
        logic [IDX_W-1:0] idx;
        logic             eos;
        logic [C_W-1:0]   c1;
        logic [C_W-1:0]   c2;
        logic [49:0]      t1;
        logic [V_W-1:0]   gg;
    } t_s1;

    typedef struct packed {
        logic [VAL_W-1:0] p;
        logic [IDX_W-1:0] idx;
        logic             eos;
        logic [C_W-1:0]   c1;
        logic [C_W-1:0]   c2;
        logic [49:0]      t1;
        logic [63:0]      t2;
    } t_s2;

    typedef struct packed {
        logic [VAL_W-1:0] p;
        logic [IDX_W-1:0] idx;
        logic             eos;
        logic [C_W-1:0]   c1;
        logic [C_W-1:0]   c2;
        logic [VAL_W-1:0] m;
        logic [V_W-1:0]   v;
    } t_s3;

    typedef struct packed {
        logic [VAL_W-1:0] p;
        logic [IDX_W-1:0] idx;
        logic             eos;
        logic [C_W-1:0]   c1;
        logic [VAL_W-1:0] lm;
        logic             neg;
    } t_sqp;

    typedef struct packed {
        logic [VAL_W-1:0] p;
        logic [IDX_W-1:0] idx;
        logic             eos;
        logic             neg;
        logic [64:0]      c1s;
        logic [52:0]      er;
        logic [63:0]      n;
    } t_x1;

    typedef struct packed {
        logic [VAL_W-1:0] p;
        logic [IDX_W-1:0] idx;
        logic             eos;
        logic             neg;
        logic [N_W-1:0]   n;
        logic [D_W-1:0]   d;
    } t_x2;

    typedef struct packed {
        logic [VAL_W-1:0] p;
        logic [IDX_W-1:0] idx;
        logic             eos;
        logic             neg;
    } t_dvp;

    typedef struct packed {
        logic [VAL_W-1:0] res;
        logic [IDX_W-1:0] idx;
        logic             eos;
    } t_fin;

    // ---------------------------------------------------------------- config
    logic [LR_W-1:0]   r_lr;
    logic [BETA_W-1:0] r_b1;
    logic [BETA_W-1:0] r_b2;
    logic [PW_W-1:0]   r_pw1;
    logic [PW_W-1:0]   r_pw2;

    logic                   cfg_wr;
    t_reg_idx               cfg_idx;
    logic [PW_W+BETA_W-1:0] pw1_prod;
    logic [PW_W+BETA_W-1:0] pw2_prod;

    // ---------------------------------------------------------------- control
    logic              en;
    logic              in_acc;
    logic              out_load;
    logic              r_clearing;
    logic [MEM_AW-1:0] r_clr_addr;

    // ---------------------------------------------------------------- pipeline
    logic r_s0_vld, r_s1_vld, r_s2_vld, r_s3_vld;
    logic r_x1_vld, r_x2_vld, r_fin_vld, r_out_vld;
    logic r_sq_vld [SQ_STAGES];
    logic r_dv_vld [DIV_STAGES];

    t_s0  r_s0;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_s3  r_s3, n_s3;
    t_sqp r_sqp [SQ_STAGES];
    t_sqp n_sqp;
    t_x1  r_x1, n_x1;
    t_x2  r_x2, n_x2;
    t_dvp r_dvp [DIV_STAGES];
    t_fin r_fin, n_fin;
    t_fin r_out;

    logic [MEM_W-1:0] mem [MEM_DEPTH];
    logic [MEM_W-1:0] r_rd;
    logic [MEM_W-1:0] r_fwd;
    logic             r_hit;
    logic             mem_we;
    logic [MEM_AW-1:0] mem_wa;
    logic [MEM_W-1:0] mem_wd;

    logic signed [VAL_W-1:0] m_old;
    logic [V_W-1:0]          v_old;
    logic signed [50:0]      m_sum;
    logic [63:0]             v_sum;
    logic [VAL_W-1:0]        m_new;
    logic [V_W-1:0]          v_new;

    logic [VAL_W-1:0]     ga;
    logic [63:0]          gsq;
    logic [BETA_W:0]      om1;
    logic [BETA_W:0]      om2;
    logic [64:0]          t2_full;
    logic [VAL_W-1:0]     ma;
    logic [55:0]          lm_full;
    logic [SQ_ROOT_W-1:0] root_s;
    logic [SQ_ROOT_W-1:0] root_r;
    logic [D_W-1:0]       d_sum;
    logic [Q_W-1:0]       quot;
    logic                 quot_sat;
    logic [Q_W-1:0]       u;
    logic signed [35:0]   r36;

    // ------------------------------------------------------------ APB port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_comb begin
        unique case (cfg_idx)
            REG_LR:  prdata = 32'(r_lr);
            REG_B1:  prdata = 32'(r_b1);
            REG_B2:  prdata = 32'(r_b2);
            default: prdata = '0;
        endcase
    end

    assign pw1_prod = r_pw1 * r_b1;
    assign pw2_prod = r_pw2 * r_b2;

    // Beta writes reload their power; a step end advances both powers unless a register write is taken with it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr  <= LR_RESET;
            r_b1  <= B1_RESET;
            r_b2  <= B2_RESET;
            r_pw1 <= {B1_RESET, BETA_W'(0)};
            r_pw2 <= {B2_RESET, BETA_W'(0)};
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_LR: begin
                    r_lr <= pwdata[LR_W-1:0];
                end
                REG_B1: begin
                    r_b1  <= pwdata[BETA_W-1:0];
                    r_pw1 <= {pwdata[BETA_W-1:0], BETA_W'(0)};
                end
                REG_B2: begin
                    r_b2  <= pwdata[BETA_W-1:0];
                    r_pw2 <= {pwdata[BETA_W-1:0], BETA_W'(0)};
                end
                default: begin
                end
            endcase
        end else if (in_acc && i_end_of_step) begin
            r_pw1 <= pw1_prod[PW_W+BETA_W-1:BETA_W];
            r_pw2 <= pw2_prod[PW_W+BETA_W-1:BETA_W];
        end
    end

    // ------------------------------------------------------------ flow control
    // Advance the whole pipe unless the final stage is full and cannot drain.
    assign out_load   = !r_out_vld || !i_out_stall;
    assign en         = !r_fin_vld || out_load;
    assign o_in_stall = r_clearing || !en;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == MEM_AW'(MEM_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------ stage 1: gradient terms
    always_comb begin
        ga       = r_s0.g[VAL_W-1] ? VAL_W'(-r_s0.g) : r_s0.g;
        gsq      = ga * ga;
        om1      = (BETA_W+1)'(1 << BETA_W) - {1'b0, r_b1};
        n_s1.p   = r_s0.p;
        n_s1.idx = r_s0.idx;
        n_s1.eos = r_s0.eos;
        n_s1.c1  = r_s0.c1;
        n_s1.c2  = r_s0.c2;
        n_s1.t1  = $signed({1'b0, om1}) * $signed(r_s0.g);
        n_s1.gg  = gsq[63:16];
    end

    // ------------------------------------------------------------ stage 2: v input term
    always_comb begin
        om2      = (BETA_W+1)'(1 << BETA_W) - {1'b0, r_b2};
        t2_full  = om2 * r_s1.gg;
        n_s2.p   = r_s1.p;
        n_s2.idx = r_s1.idx;
        n_s2.eos = r_s1.eos;
        n_s2.c1  = r_s1.c1;
        n_s2.c2  = r_s1.c2;
        n_s2.t1  = r_s1.t1;
        n_s2.t2  = t2_full[63:0];
    end

    // ------------------------------------------------------------ stage 3: moment update
    // Take the forwarded entry when the previous beat wrote the same slot.
    always_comb begin
        m_old    = r_hit ? $signed(r_fwd[MEM_W-1:V_W]) : $signed(r_rd[MEM_W-1:V_W]);
        v_old    = r_hit ? r_fwd[V_W-1:0] : r_rd[V_W-1:0];
        m_sum    = $signed({1'b0, r_b1}) * m_old + $signed(r_s2.t1);
        v_sum    = r_b2 * v_old + r_s2.t2;
        m_new    = m_sum[VAL_W+15:16];
        v_new    = v_sum[63:16];
        n_s3.p   = r_s2.p;
        n_s3.idx = r_s2.idx;
        n_s3.eos = r_s2.eos;
        n_s3.c1  = r_s2.c1;
        n_s3.c2  = r_s2.c2;
        n_s3.m   = m_new;
        n_s3.v   = v_new;
    end

    assign mem_we = r_clearing || (en && r_s2_vld);
    assign mem_wa = r_clearing ? r_clr_addr : r_s2.idx[MEM_AW-1:0];
    assign mem_wd = r_clearing ? '0 : {m_new, v_new};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (en) begin
            r_rd <= mem[r_s1.idx[MEM_AW-1:0]];
        end
    end

    // ------------------------------------------------------------ stage 4: step numerator
    always_comb begin
        ma        = r_s3.m[VAL_W-1] ? VAL_W'(-r_s3.m) : r_s3.m;
        lm_full   = r_lr * ma;
        n_sqp.p   = r_s3.p;
        n_sqp.idx = r_s3.idx;
        n_sqp.eos = r_s3.eos;
        n_sqp.c1  = r_s3.c1;
        n_sqp.lm  = lm_full[55:24];
        n_sqp.neg = r_s3.m[VAL_W-1];
    end

    adam_sqrt u_sqrt_v (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_radicand ({r_s3.v, 16'h0}),
        .o_root     (root_s)
    );

    adam_sqrt u_sqrt_c2 (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_radicand ({3'b000, r_s3.c2, 28'h0}),
        .o_root     (root_r)
    );

    // ------------------------------------------------------------ products after the roots
    always_comb begin
        n_x1.p   = r_sqp[SQ_STAGES-1].p;
        n_x1.idx = r_sqp[SQ_STAGES-1].idx;
        n_x1.eos = r_sqp[SQ_STAGES-1].eos;
        n_x1.neg = r_sqp[SQ_STAGES-1].neg;
        n_x1.c1s = r_sqp[SQ_STAGES-1].c1 * root_s;
        n_x1.er  = EPS_Q40 * root_r;
        n_x1.n   = r_sqp[SQ_STAGES-1].lm * root_r;
    end

    // Denominator; a zero never reaches the divider.
    always_comb begin
        d_sum    = D_W'(r_x1.c1s[63:16]) + D_W'(r_x1.er[52:30]);
        n_x2.p   = r_x1.p;
        n_x2.idx = r_x1.idx;
        n_x2.eos = r_x1.eos;
        n_x2.neg = r_x1.neg;
        n_x2.n   = r_x1.n[N_W-1:0];
        n_x2.d   = (d_sum == '0) ? D_W'(1) : d_sum;
    end

    adam_div u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r_x2.n),
        .i_den  (r_x2.d),
        .o_quot (quot),
        .o_sat  (quot_sat)
    );

    // ------------------------------------------------------------ apply step, saturate
    always_comb begin
        u = (quot_sat || quot > U_CAP) ? U_CAP : quot;
        if (r_dvp[DIV_STAGES-1].neg) begin
            r36 = 36'($signed(r_dvp[DIV_STAGES-1].p)) + $signed({2'b00, u});
        end else begin
            r36 = 36'($signed(r_dvp[DIV_STAGES-1].p)) - $signed({2'b00, u});
        end
        if (r36 > 36'sd2147483647) begin
            n_fin.res = 32'h7FFF_FFFF;
        end else if (r36 < -36'sd2147483648) begin
            n_fin.res = 32'h8000_0000;
        end else begin
            n_fin.res = r36[VAL_W-1:0];
        end
        n_fin.idx = r_dvp[DIV_STAGES-1].idx;
        n_fin.eos = r_dvp[DIV_STAGES-1].eos;
    end

    // ------------------------------------------------------------ valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld  <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_x1_vld  <= 1'b0;
            r_x2_vld  <= 1'b0;
            r_fin_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_hit     <= 1'b0;
            for (int k = 0; k < SQ_STAGES; k++) begin
                r_sq_vld[k] <= 1'b0;
            end
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_dv_vld[k] <= 1'b0;
            end
        end else begin
            if (en) begin
                r_s0_vld    <= in_acc;
                r_s1_vld    <= r_s0_vld;
                r_s2_vld    <= r_s1_vld;
                r_s3_vld    <= r_s2_vld;
                r_hit       <= r_s1_vld && r_s2_vld &&
                               (r_s1.idx[MEM_AW-1:0] == r_s2.idx[MEM_AW-1:0]);
                r_sq_vld[0] <= r_s3_vld;
                for (int k = 1; k < SQ_STAGES; k++) begin
                    r_sq_vld[k] <= r_sq_vld[k-1];
                end
                r_x1_vld    <= r_sq_vld[SQ_STAGES-1];
                r_x2_vld    <= r_x1_vld;
                r_dv_vld[0] <= r_x2_vld;
                for (int k = 1; k < DIV_STAGES; k++) begin
                    r_dv_vld[k] <= r_dv_vld[k-1];
                end
                r_fin_vld   <= r_dv_vld[DIV_STAGES-1];
            end
            if (out_load) begin
                r_out_vld <= r_fin_vld;
            end
        end
    end

    // ------------------------------------------------------------ payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0.p   <= i_param_value;
            r_s0.g   <= i_gradient;
            r_s0.idx <= i_param_index;
            r_s0.eos <= i_end_of_step;
            r_s0.c1  <= {1'b1, PW_W'(0)} - {1'b0, r_pw1};
            r_s0.c2  <= {1'b1, PW_W'(0)} - {1'b0, r_pw2};
            r_s1     <= n_s1;
            r_s2     <= n_s2;
            r_s3     <= n_s3;
            r_fwd    <= {m_new, v_new};
            r_sqp[0] <= n_sqp;
            for (int k = 1; k < SQ_STAGES; k++) begin
                r_sqp[k] <= r_sqp[k-1];
            end
            r_x1     <= n_x1;
            r_x2     <= n_x2;
            r_dvp[0] <= '{p: r_x2.p, idx: r_x2.idx, eos: r_x2.eos, neg: r_x2.neg};
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_dvp[k] <= r_dvp[k-1];
            end
            r_fin    <= n_fin;
        end
        if (out_load) begin
            r_out <= r_fin;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_new_value    = r_out.res;
    assign o_result_index = r_out.idx;
    assign o_step_done    = r_out.eos;

    // ------------------------------------------------------------ checks
    a_clr_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> o_in_stall)
        else $error("input beat taken during memory clear");

    a_clr_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> (!r_s2_vld && !r_s1_vld))
        else $error("moment update in flight during memory clear");

    a_fwd_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit |-> r_s2_vld)
        else $error("forward selected without a live beat");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |-> (r_fin_vld && r_out_vld && i_out_stall))
        else $error("pipe held without a blocked result");

endmodule
